FILE: hw/rtl/dnsap_pkg.sv
// dnsap_pkg: shared types and constants for the dns answer record parser
// no dependencies; imported by the classifier and the top level

package dnsap_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QPTR   = 4'd2,
        PH_QTAIL  = 4'd3,
        PH_ANAME  = 4'd4,
        PH_APTR   = 4'd5,
        PH_AFIXED = 4'd6,
        PH_ADATA  = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    localparam logic [2:0] KIND_A     = 3'd0;
    localparam logic [2:0] KIND_AAAA  = 3'd1;
    localparam logic [2:0] KIND_CNAME = 3'd2;
    localparam logic [2:0] KIND_OTHER = 3'd3;
    localparam logic [2:0] KIND_TRUNC = 3'd4;

    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [3:0]  HEADER_LEN = 4'd12;
    localparam logic [3:0]  QTAIL_LEN  = 4'd4;
    localparam logic [3:0]  AFIXED_LEN = 4'd10;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_AAAA  = 16'd28;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] LEN_A      = 16'd4;
    localparam logic [15:0] LEN_AAAA   = 16'd16;
    localparam logic [15:0] ADDR_BYTES = 16'd16;

    // classification of one completed record
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } t_rec_class;

endpackage

FILE: hw/rtl/dnsap_if.sv
// dnsap_if: valid/ready channel interfaces for message bytes and answer records
// no dependencies

interface dnsap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       final_byte;

    modport source (output valid, output message_byte, output final_byte, input ready);
    modport sink   (input valid, input message_byte, input final_byte, output ready);
endinterface

interface dnsap_rec_if;
    logic        valid;
    logic        ready;
    logic [15:0] record_index;
    logic [2:0]  record_kind;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] data_length;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic        last_record;

    modport source (output valid, output record_index, output record_kind,
                    output record_type, output record_class, output time_to_live,
                    output data_length, output address_high, output address_low,
                    output last_record, input ready);
    modport sink   (input valid, input record_index, input record_kind,
                    input record_type, input record_class, input time_to_live,
                    input data_length, input address_high, input address_low,
                    input last_record, output ready);
endinterface

FILE: hw/rtl/dnsap_classify.sv
// dnsap_classify: record kind and address selection for a completed answer
// depends on dnsap_pkg

module dnsap_classify (
    input  logic [15:0]          i_type,
    input  logic [15:0]          i_class,
    input  logic [15:0]          i_len,
    input  logic [63:0]          i_acc_hi,
    input  logic [63:0]          i_acc_lo,
    output dnsap_pkg::t_rec_class o_class
);
    import dnsap_pkg::*;

    always_comb begin
        o_class.kind    = KIND_OTHER;
        o_class.addr_hi = '0;
        o_class.addr_lo = '0;
        if (i_type == TYPE_A && i_class == CLASS_IN && i_len == LEN_A) begin
            o_class.kind    = KIND_A;
            o_class.addr_lo = {32'd0, i_acc_lo[31:0]};
        end else if (i_type == TYPE_AAAA && i_class == CLASS_IN && i_len == LEN_AAAA) begin
            o_class.kind    = KIND_AAAA;
            o_class.addr_hi = i_acc_hi;
            o_class.addr_lo = i_acc_lo;
        end else if (i_type == TYPE_CNAME) begin
            o_class.kind    = KIND_CNAME;
        end
    end

endmodule

FILE: hw/rtl/dns_answer_record_parser_top.sv
// dns_answer_record_parser_top: byte-serial dns response parser, one record per answer
// depends on dnsap_pkg, dnsap_if and dnsap_classify
//
// usage
//   i_byte carries the message one byte per beat; final_byte marks its last byte
//   o_rec carries one beat per answer record, plus one truncation beat
//     (kind truncated, last_record set) when a message ends mid-parse
//   a byte is taken every cycle while i_byte.ready is high: the parse state and
//   field registers update on the accepting edge, and a record completed by that
//   byte shows on o_rec in the next cycle
//   the result register is the only buffer: i_byte.ready drops only while a
//   record is held and o_rec.ready is low, so a stalled sink stalls the source
//   and no record is lost or repeated
//   reset (synchronous, active low) clears the parse state to the header phase
//   and empties the result register
//   the final byte of each message returns the parser to its reset state, so
//   the next byte begins a new message
//   bytes after the last answer are absorbed without output

module dns_answer_record_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnsap_byte_if.sink    i_byte,
    dnsap_rec_if.source   o_rec
);
    import dnsap_pkg::*;

    // parse state
    t_phase      r_phase,    n_phase;
    logic [3:0]  r_fcb,      n_fcb;
    logic [7:0]  r_lbl,      n_lbl;
    logic [15:0] r_q,        n_q;
    logic [15:0] r_a,        n_a;
    logic [15:0] r_num,      n_num;
    logic [15:0] r_type,     n_type;
    logic [15:0] r_class,    n_class;
    logic [31:0] r_ttl,      n_ttl;
    logic [15:0] r_len,      n_len;
    logic [15:0] r_left,     n_left;
    logic [63:0] r_acc_hi,   n_acc_hi;
    logic [63:0] r_acc_lo,   n_acc_lo;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_index;
    logic [2:0]  r_out_kind;
    logic [15:0] r_out_type;
    logic [15:0] r_out_class;
    logic [31:0] r_out_ttl;
    logic [15:0] r_out_len;
    logic [63:0] r_out_hi;
    logic [63:0] r_out_lo;
    logic        r_out_last;

    // field step results, before answer restart and end-of-message handling
    t_phase      w_phase;
    logic [3:0]  w_fcb;
    logic [3:0]  w_cnt_inc;
    logic [7:0]  w_lbl;
    logic [15:0] w_q;
    logic [15:0] w_a;
    logic [15:0] w_type;
    logic [15:0] w_class;
    logic [31:0] w_ttl;
    logic [15:0] w_len;
    logic [15:0] w_left;
    logic [15:0] w_used;
    logic [63:0] w_acc_hi;
    logic [63:0] w_acc_lo;
    logic        w_finish;
    logic        w_next_section;
    logic        w_start;
    logic        w_accept;
    logic [7:0]  w_b;

    // result beat being built
    logic        w_emit;
    logic [15:0] w_res_index;
    logic [2:0]  w_res_kind;
    logic [15:0] w_res_type;
    logic [15:0] w_res_class;
    logic [31:0] w_res_ttl;
    logic [15:0] w_res_len;
    logic [63:0] w_res_hi;
    logic [63:0] w_res_lo;
    logic        w_res_last;

    t_rec_class  w_cls;

    assign w_b          = i_byte.message_byte;
    assign i_byte.ready = !r_out_valid || o_rec.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_cnt_inc    = r_fcb + 4'd1;
    assign w_used       = r_len - r_left;

    // per-byte field update
    always_comb begin
        w_phase        = r_phase;
        w_fcb          = r_fcb;
        w_lbl          = r_lbl;
        w_q            = r_q;
        w_type         = r_type;
        w_class        = r_class;
        w_ttl          = r_ttl;
        w_len          = r_len;
        w_left         = r_left;
        w_acc_hi       = r_acc_hi;
        w_acc_lo       = r_acc_lo;
        w_finish       = 1'b0;
        w_next_section = 1'b0;
        w_a            = r_a;
        case (r_phase)
            PH_HEADER: begin
                if (r_fcb == 4'd4) w_q = {w_b, 8'd0};
                if (r_fcb == 4'd5) w_q = {r_q[15:8], w_b};
                if (r_fcb == 4'd6) w_a = {w_b, 8'd0};
                if (r_fcb == 4'd7) w_a = {r_a[15:8], w_b};
                if (w_cnt_inc >= HEADER_LEN) w_next_section = 1'b1;
                else w_fcb = w_cnt_inc;
            end
            PH_QNAME, PH_ANAME: begin
                if (r_lbl != 8'd0) begin
                    w_lbl = r_lbl - 8'd1;
                end else if (w_b == 8'd0) begin
                    w_phase = (r_phase == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
                    w_fcb   = 4'd0;
                end else if ((w_b & PTR_MASK) == PTR_MASK) begin
                    // compression pointer: one more byte ends the name
                    w_phase = (r_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else begin
                    w_lbl = w_b;
                end
            end
            PH_QPTR: begin
                w_phase = PH_QTAIL;
                w_fcb   = 4'd0;
            end
            PH_APTR: begin
                w_phase = PH_AFIXED;
                w_fcb   = 4'd0;
            end
            PH_QTAIL: begin
                if (w_cnt_inc >= QTAIL_LEN) begin
                    w_q            = r_q - 16'd1;
                    w_next_section = 1'b1;
                end else begin
                    w_fcb = w_cnt_inc;
                end
            end
            PH_AFIXED: begin
                if (r_fcb < 4'd2)      w_type  = {r_type[7:0], w_b};
                else if (r_fcb < 4'd4) w_class = {r_class[7:0], w_b};
                else if (r_fcb < 4'd8) w_ttl   = {r_ttl[23:0], w_b};
                else                   w_len   = {r_len[7:0], w_b};
                if (w_cnt_inc >= AFIXED_LEN) begin
                    w_fcb    = 4'd0;
                    w_left   = w_len;
                    w_acc_hi = '0;
                    w_acc_lo = '0;
                    if (w_len == 16'd0) w_finish = 1'b1;
                    else w_phase = PH_ADATA;
                end else begin
                    w_fcb = w_cnt_inc;
                end
            end
            PH_ADATA: begin
                // only the first sixteen data bytes reach the address register
                if (w_used < ADDR_BYTES) begin
                    w_acc_hi = {r_acc_hi[55:0], r_acc_lo[63:56]};
                    w_acc_lo = {r_acc_lo[55:0], w_b};
                end
                w_left = r_left - 16'd1;
                if (w_left == 16'd0) w_finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    dnsap_classify u_classify (
        .i_type   (w_type),
        .i_class  (w_class),
        .i_len    (w_len),
        .i_acc_hi (w_acc_hi),
        .i_acc_lo (w_acc_lo),
        .o_class  (w_cls)
    );

    // section changes, record completion and end of message
    always_comb begin
        n_phase  = w_phase;
        n_fcb    = w_fcb;
        n_lbl    = w_lbl;
        n_q      = w_q;
        n_a      = w_a;
        n_num    = r_num;
        n_type   = w_type;
        n_class  = w_class;
        n_ttl    = w_ttl;
        n_len    = w_len;
        n_left   = w_left;
        n_acc_hi = w_acc_hi;
        n_acc_lo = w_acc_lo;
        w_start  = 1'b0;

        w_emit      = w_finish;
        w_res_index = r_num;
        w_res_kind  = w_cls.kind;
        w_res_type  = w_type;
        w_res_class = w_class;
        w_res_ttl   = w_ttl;
        w_res_len   = w_len;
        w_res_hi    = w_cls.addr_hi;
        w_res_lo    = w_cls.addr_lo;
        w_res_last  = (r_a <= 16'd1);

        if (w_next_section) begin
            n_fcb = 4'd0;
            n_lbl = 8'd0;
            if (w_q != 16'd0)      n_phase = PH_QNAME;
            else if (n_a != 16'd0) w_start = 1'b1;
            else                   n_phase = PH_DONE;
        end

        if (w_finish) begin
            n_num = r_num + 16'd1;
            n_a   = r_a - 16'd1;
            if (n_a == 16'd0) n_phase = PH_DONE;
            else w_start = 1'b1;
        end

        if (w_start) begin
            n_phase  = PH_ANAME;
            n_fcb    = 4'd0;
            n_lbl    = 8'd0;
            n_type   = '0;
            n_class  = '0;
            n_ttl    = '0;
            n_len    = '0;
            n_left   = '0;
            n_acc_hi = '0;
            n_acc_lo = '0;
        end

        if (i_byte.final_byte) begin
            // truncation beat replaces any record completed by the same byte
            if (n_phase != PH_DONE) begin
                w_emit      = 1'b1;
                w_res_index = n_num;
                w_res_kind  = KIND_TRUNC;
                w_res_type  = n_type;
                w_res_class = n_class;
                w_res_ttl   = n_ttl;
                w_res_len   = n_len;
                w_res_hi    = '0;
                w_res_lo    = '0;
                w_res_last  = 1'b1;
            end
            n_phase  = PH_HEADER;
            n_fcb    = '0;
            n_lbl    = '0;
            n_q      = '0;
            n_a      = '0;
            n_num    = '0;
            n_type   = '0;
            n_class  = '0;
            n_ttl    = '0;
            n_len    = '0;
            n_left   = '0;
            n_acc_hi = '0;
            n_acc_lo = '0;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_fcb    <= '0;
            r_lbl    <= '0;
            r_q      <= '0;
            r_a      <= '0;
            r_num    <= '0;
            r_type   <= '0;
            r_class  <= '0;
            r_ttl    <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_acc_hi <= '0;
            r_acc_lo <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_fcb    <= n_fcb;
            r_lbl    <= n_lbl;
            r_q      <= n_q;
            r_a      <= n_a;
            r_num    <= n_num;
            r_type   <= n_type;
            r_class  <= n_class;
            r_ttl    <= n_ttl;
            r_len    <= n_len;
            r_left   <= n_left;
            r_acc_hi <= n_acc_hi;
            r_acc_lo <= n_acc_lo;
        end
    end

    // result register: held until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_index <= w_res_index;
            r_out_kind  <= w_res_kind;
            r_out_type  <= w_res_type;
            r_out_class <= w_res_class;
            r_out_ttl   <= w_res_ttl;
            r_out_len   <= w_res_len;
            r_out_hi    <= w_res_hi;
            r_out_lo    <= w_res_lo;
            r_out_last  <= w_res_last;
        end
    end

    assign o_rec.valid        = r_out_valid;
    assign o_rec.record_index = r_out_index;
    assign o_rec.record_kind  = r_out_kind;
    assign o_rec.record_type  = r_out_type;
    assign o_rec.record_class = r_out_class;
    assign o_rec.time_to_live = r_out_ttl;
    assign o_rec.data_length  = r_out_len;
    assign o_rec.address_high = r_out_hi;
    assign o_rec.address_low  = r_out_lo;
    assign o_rec.last_record  = r_out_last;

endmodule

FILE: tb/sv/dnsap_record_checker.sv
`timescale 1ns / 1ps
// dnsap_record_checker: watches the byte and record channels of the dns answer parser,
// predicts every answer record and compares it with what the parser delivers
// depends on dnsap_pkg and dnsap_if

module dnsap_record_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dnsap_byte_if i_byte,
    dnsap_rec_if  i_rec,
    output int    o_fail_count,
    output int    o_pending_count
);
    import dnsap_pkg::*;

    typedef struct packed {
        logic [15:0] rec_index;
        logic [2:0]  kind;
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [31:0] ttl;
        logic [15:0] rlen;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic        last;
    } t_answer_rec;

    // predicted parse state
    t_phase      cur_phase;
    logic [3:0]  fcount;
    logic [7:0]  label_left;
    logic [15:0] q_left;
    logic [15:0] a_left;
    logic [15:0] ans_num;
    logic [15:0] typ;
    logic [15:0] cls;
    logic [31:0] ttl;
    logic [15:0] rlen;
    logic [15:0] rleft;
    logic [63:0] acc_hi;
    logic [63:0] acc_lo;

    t_answer_rec expected_records[$];
    int          mismatch_count = 0;
    int          pending_count = 0;

    t_answer_rec got_rec;
    t_answer_rec want_rec;
    t_answer_rec new_rec;
    logic        new_made;

    assign o_fail_count    = mismatch_count;
    assign o_pending_count = pending_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_parse();
        cur_phase  = PH_HEADER;
        fcount     = '0;
        label_left = '0;
        q_left     = '0;
        a_left     = '0;
        ans_num    = '0;
        typ        = '0;
        cls        = '0;
        ttl        = '0;
        rlen       = '0;
        rleft      = '0;
        acc_hi     = '0;
        acc_lo     = '0;
    endtask

    task automatic start_answer();
        cur_phase  = PH_ANAME;
        fcount     = '0;
        label_left = '0;
        typ        = '0;
        cls        = '0;
        ttl        = '0;
        rlen       = '0;
        rleft      = '0;
        acc_hi     = '0;
        acc_lo     = '0;
    endtask

    task automatic next_section();
        fcount     = '0;
        label_left = '0;
        if (q_left != 0)
            cur_phase = PH_QNAME;
        else if (a_left != 0)
            start_answer();
        else
            cur_phase = PH_DONE;
    endtask

    function automatic t_answer_rec make_record(input logic [2:0] kind,
                                                input logic [63:0] hi,
                                                input logic [63:0] lo,
                                                input logic last);
        t_answer_rec r;
        r.rec_index = ans_num;
        r.kind      = kind;
        r.rtype     = typ;
        r.rclass    = cls;
        r.ttl       = ttl;
        r.rlen      = rlen;
        r.addr_hi   = hi;
        r.addr_lo   = lo;
        r.last      = last;
        return r;
    endfunction

    task automatic finish_record(output t_answer_rec rec);
        if (typ == TYPE_A && cls == CLASS_IN && rlen == LEN_A)
            rec = make_record(KIND_A, '0, {32'h0, acc_lo[31:0]}, a_left <= 1);
        else if (typ == TYPE_AAAA && cls == CLASS_IN && rlen == LEN_AAAA)
            rec = make_record(KIND_AAAA, acc_hi, acc_lo, a_left <= 1);
        else if (typ == TYPE_CNAME)
            rec = make_record(KIND_CNAME, '0, '0, a_left <= 1);
        else
            rec = make_record(KIND_OTHER, '0, '0, a_left <= 1);
        ans_num = ans_num + 16'd1;
        a_left  = a_left - 16'd1;
        if (a_left == 0)
            cur_phase = PH_DONE;
        else
            start_answer();
    endtask

    // a pointer ends the name wherever it stands, after its second byte
    task automatic name_byte(input logic [7:0] b, input t_phase ptr_phase,
                             input t_phase end_phase);
        if (label_left != 0) begin
            label_left = label_left - 8'd1;
        end else if (b == 8'h00) begin
            cur_phase = end_phase;
            fcount    = '0;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
            cur_phase = ptr_phase;
        end else begin
            label_left = b;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin,
                              output logic made, output t_answer_rec rec);
        logic [3:0] c;
        c    = fcount;
        made = 1'b0;
        rec  = '0;
        case (cur_phase)
            PH_HEADER: begin
                if (c == 4'd4)      q_left = {b, 8'h00};
                else if (c == 4'd5) q_left = q_left | {8'h00, b};
                else if (c == 4'd6) a_left = {b, 8'h00};
                else if (c == 4'd7) a_left = a_left | {8'h00, b};
                c = c + 4'd1;
                if (c >= HEADER_LEN) next_section();
                else fcount = c;
            end
            PH_QNAME: name_byte(b, PH_QPTR, PH_QTAIL);
            PH_QPTR: begin
                cur_phase = PH_QTAIL;
                fcount    = '0;
            end
            PH_QTAIL: begin
                c = c + 4'd1;
                if (c >= QTAIL_LEN) begin
                    q_left = q_left - 16'd1;
                    next_section();
                end else begin
                    fcount = c;
                end
            end
            PH_ANAME: name_byte(b, PH_APTR, PH_AFIXED);
            PH_APTR: begin
                cur_phase = PH_AFIXED;
                fcount    = '0;
            end
            PH_AFIXED: begin
                if (c < 4'd2)      typ  = {typ[7:0], b};
                else if (c < 4'd4) cls  = {cls[7:0], b};
                else if (c < 4'd8) ttl  = {ttl[23:0], b};
                else               rlen = {rlen[7:0], b};
                c = c + 4'd1;
                if (c >= AFIXED_LEN) begin
                    fcount = '0;
                    rleft  = rlen;
                    acc_hi = '0;
                    acc_lo = '0;
                    if (rlen == 0) begin
                        finish_record(rec);
                        made = 1'b1;
                    end else begin
                        cur_phase = PH_ADATA;
                    end
                end else begin
                    fcount = c;
                end
            end
            PH_ADATA: begin
                if ((rlen - rleft) < ADDR_BYTES) begin
                    acc_hi = {acc_hi[55:0], acc_lo[63:56]};
                    acc_lo = {acc_lo[55:0], b};
                end
                rleft = rleft - 16'd1;
                if (rleft == 0) begin
                    finish_record(rec);
                    made = 1'b1;
                end
            end
            default: ;
        endcase
        if (fin) begin
            if (cur_phase != PH_DONE) begin
                rec  = make_record(KIND_TRUNC, '0, '0, 1'b1);
                made = 1'b1;
            end
            clear_parse();
        end
    endtask

    // records leaving at this edge come from earlier bytes, so compare before predicting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_records.delete();
        end else begin
            if (i_rec.valid && i_rec.ready) begin
                got_rec = '{i_rec.record_index, i_rec.record_kind, i_rec.record_type,
                            i_rec.record_class, i_rec.time_to_live, i_rec.data_length,
                            i_rec.address_high, i_rec.address_low, i_rec.last_record};
                if (expected_records.size() == 0) begin
                    report_mismatch("record with nothing expected", got_rec.rec_index, '0);
                end else begin
                    want_rec = expected_records.pop_front();
                    if (got_rec.rec_index !== want_rec.rec_index)
                        report_mismatch("record_index", got_rec.rec_index, want_rec.rec_index);
                    if (got_rec.kind !== want_rec.kind)
                        report_mismatch("record_kind", got_rec.kind, want_rec.kind);
                    if (got_rec.rtype !== want_rec.rtype)
                        report_mismatch("record_type", got_rec.rtype, want_rec.rtype);
                    if (got_rec.rclass !== want_rec.rclass)
                        report_mismatch("record_class", got_rec.rclass, want_rec.rclass);
                    if (got_rec.ttl !== want_rec.ttl)
                        report_mismatch("time_to_live", got_rec.ttl, want_rec.ttl);
                    if (got_rec.rlen !== want_rec.rlen)
                        report_mismatch("data_length", got_rec.rlen, want_rec.rlen);
                    if (got_rec.addr_hi !== want_rec.addr_hi)
                        report_mismatch("address_high", got_rec.addr_hi, want_rec.addr_hi);
                    if (got_rec.addr_lo !== want_rec.addr_lo)
                        report_mismatch("address_low", got_rec.addr_lo, want_rec.addr_lo);
                    if (got_rec.last !== want_rec.last)
                        report_mismatch("last_record", got_rec.last, want_rec.last);
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                parse_byte(i_byte.message_byte, i_byte.final_byte, new_made, new_rec);
                if (new_made)
                    expected_records.push_back(new_rec);
            end
        end
        pending_count = expected_records.size();
    end

endmodule

FILE: tb/sv/dns_answer_record_parser_top_test.sv
`timescale 1ns / 1ps
// dns_answer_record_parser_top_test: builds dns response messages and streams them into
// the parser byte by byte; depends on dnsap_pkg, dnsap_if, the parser and dnsap_record_checker

module dns_answer_record_parser_top_test;
    import dnsap_pkg::*;

    localparam int RANDOM_BYTES = 1300;

    logic       i_clk;
    logic       i_rst_n;
    int         fail_count;
    int         records_pending;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         bytes_sent;
    logic [7:0] msg_bytes[$];

    dnsap_byte_if byte_ch();
    dnsap_rec_if  rec_ch();

    dns_answer_record_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_rec   (rec_ch)
    );

    // predicts and compares on its own, hands back failures and open predictions
    dnsap_record_checker rec_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (byte_ch),
        .i_rec           (rec_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (records_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("[dns_answer_record_parser_top] ERROR");
        $finish;
    end

    // record sink: stalls at random, the rate set by the current phase
    always @(posedge i_clk)
        rec_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // one byte beat; ready is sampled at the falling edge, where it is settled,
    // and the beat is taken at the rising edge that follows
    task automatic send_beat(input logic [7:0] b, input logic fin);
        logic took;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.message_byte <= b;
        byte_ch.final_byte   <= fin;
        forever begin
            @(negedge i_clk);
            took = byte_ch.ready;
            @(posedge i_clk);
            if (took) break;
        end
        bytes_sent++;
    endtask

    // sends the built message, or only its first keep bytes; final goes on the last beat sent
    task automatic send_message(input int unsigned keep);
        int unsigned n;
        n = msg_bytes.size();
        if (keep != 0 && keep < n)
            n = keep;
        for (int unsigned i = 0; i < n; i++)
            send_beat(msg_bytes[i], i == n - 1);
        msg_bytes.delete();
    endtask

    // id and flags are random, counts big-endian
    task automatic add_header(input logic [15:0] qd, input logic [15:0] an);
        repeat (4) msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(qd[15:8]);
        msg_bytes.push_back(qd[7:0]);
        msg_bytes.push_back(an[15:8]);
        msg_bytes.push_back(an[7:0]);
        repeat (4) msg_bytes.push_back(8'($urandom));
    endtask

    // lead, when nonzero, is a long label whose length byte has reserved top bits;
    // label contents are fully random, so zero and pointer-like bytes show up inside labels
    task automatic add_name(input int unsigned labels, input bit ptr_end,
                            input logic [7:0] lead);
        int unsigned len;
        if (lead != 8'h00) begin
            msg_bytes.push_back(lead);
            repeat (lead) msg_bytes.push_back(8'($urandom));
        end
        repeat (labels) begin
            len = $urandom_range(1, 4);
            msg_bytes.push_back(8'(len));
            repeat (len) msg_bytes.push_back(8'($urandom));
        end
        if (ptr_end) begin
            msg_bytes.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
            msg_bytes.push_back(8'($urandom));
        end else begin
            msg_bytes.push_back(8'h00);
        end
    endtask

    // fixed part of an answer plus rlen random data bytes
    task automatic add_rr(input logic [15:0] rtype, input logic [15:0] rclass,
                          input logic [15:0] rlen, input logic [31:0] ttl);
        msg_bytes.push_back(rtype[15:8]);
        msg_bytes.push_back(rtype[7:0]);
        msg_bytes.push_back(rclass[15:8]);
        msg_bytes.push_back(rclass[7:0]);
        msg_bytes.push_back(ttl[31:24]);
        msg_bytes.push_back(ttl[23:16]);
        msg_bytes.push_back(ttl[15:8]);
        msg_bytes.push_back(ttl[7:0]);
        msg_bytes.push_back(rlen[15:8]);
        msg_bytes.push_back(rlen[7:0]);
        repeat (rlen) msg_bytes.push_back(8'($urandom));
    endtask

    initial begin
        int unsigned pick;
        int unsigned qd;
        int unsigned an;
        int unsigned keep;
        logic [7:0]  lead;

        // byte inputs known from time zero, record ready from the first edge,
        // reset held low before the directed messages
        i_rst_n              <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.message_byte <= 8'h00;
        byte_ch.final_byte   <= 1'b0;
        src_idle_pct = 34;
        snk_idle_pct = 86;
        bytes_sent   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed messages ----

        // header alone, no questions and no answers: nothing comes out
        add_header(16'd0, 16'd0);
        send_message(0);

        // message ends inside the header: truncation beat at index 0
        add_header(16'd1, 16'd1);
        send_message(6);

        // one question, then answers of every kind and the odd shapes
        add_header(16'd1, 16'd7);
        add_name(2, 1'b0, 8'h00);
        repeat (4) msg_bytes.push_back(8'($urandom));
        // pointer as the very first name byte, A with ttl zero
        add_name(0, 1'b1, 8'h00);
        add_rr(TYPE_A, CLASS_IN, LEN_A, 32'h0000_0000);
        // pointer after a label, AAAA with the largest ttl
        add_name(1, 1'b1, 8'h00);
        add_rr(TYPE_AAAA, CLASS_IN, LEN_AAAA, 32'hFFFF_FFFF);
        // length byte with top bits 01 taken as a plain label
        add_name(1, 1'b0, 8'h41);
        add_rr(TYPE_CNAME, CLASS_IN, 16'd6, $urandom);
        // length byte with top bits 10, all-ones type and class, empty data
        add_name(0, 1'b0, 8'h80);
        add_rr(16'hFFFF, 16'hFFFF, 16'd0, $urandom);
        // A-shaped but not class in
        add_name(1, 1'b1, 8'h00);
        add_rr(TYPE_A, 16'd2, LEN_A, $urandom);
        // data longer than the address register
        add_name(0, 1'b1, 8'h00);
        add_rr(TYPE_AAAA, CLASS_IN, 16'd24, $urandom);
        // type A with an AAAA-sized payload
        add_name(0, 1'b0, 8'h00);
        add_rr(TYPE_A, CLASS_IN, LEN_AAAA, $urandom);
        // junk after the last answer is absorbed
        repeat (3) msg_bytes.push_back(8'($urandom));
        send_message(0);

        // final byte closes the first of two answers: only the truncation beat
        add_header(16'd0, 16'd2);
        add_name(0, 1'b1, 8'h00);
        add_rr(TYPE_A, CLASS_IN, LEN_A, $urandom);
        send_message(0);

        // final byte closes the only answer: a normal record, no truncation
        add_header(16'd0, 16'd1);
        add_name(1, 1'b0, 8'h00);
        add_rr(TYPE_AAAA, CLASS_IN, LEN_AAAA, $urandom);
        send_message(0);

        // ---- random messages ----
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            // idle profile follows progress; at the first switch the source
            // holds off until every predicted record has drained
            if (src_idle_pct == 34 && bytes_sent >= RANDOM_BYTES / 3) begin
                byte_ch.valid <= 1'b0;
                do @(posedge i_clk); while (records_pending != 0);
                src_idle_pct = 86;
                snk_idle_pct = 34;
            end else if (src_idle_pct == 86 && bytes_sent >= 2 * RANDOM_BYTES / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                // well-formed message, sometimes cut short or with trailing junk
                qd = $urandom_range(0, 2);
                an = (pick < 80) ? $urandom_range(1, 4) : 0;
                add_header(16'(qd), 16'(an));
                repeat (qd) begin
                    add_name($urandom_range(0, 2), 1'($urandom_range(0, 1)), 8'h00);
                    repeat (4) msg_bytes.push_back(8'($urandom));
                end
                repeat (an) begin
                    lead = ($urandom_range(0, 39) == 0) ?
                           {2'($urandom_range(1, 2)), 6'($urandom_range(0, 7))} : 8'h00;
                    add_name($urandom_range(0, 2), 1'($urandom_range(0, 1)), lead);
                    case ($urandom_range(0, 5))
                        0: add_rr(TYPE_A, CLASS_IN, LEN_A, $urandom);
                        1: add_rr(TYPE_AAAA, CLASS_IN, LEN_AAAA, $urandom);
                        2: add_rr(TYPE_CNAME, 16'($urandom), 16'($urandom_range(0, 12)),
                                  $urandom);
                        // near misses of A and AAAA, with an exact match now and then
                        3: add_rr(TYPE_A, 16'($urandom_range(0, 3)),
                                  16'($urandom_range(3, 5)), $urandom);
                        4: add_rr(TYPE_AAAA, 16'($urandom_range(0, 2)),
                                  16'($urandom_range(14, 20)), $urandom);
                        default: add_rr(16'($urandom), 16'($urandom),
                                        16'($urandom_range(0, 24)), $urandom);
                    endcase
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
                keep = ($urandom_range(0, 5) == 0) ? $urandom_range(1, msg_bytes.size()) : 0;
                send_message(keep);
            end else begin
                // pure noise, counts and names included
                repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
                send_message(0);
            end
        end

        // drain, then wait for anything late
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (records_pending != 0);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && records_pending == 0)
            $display("[dns_answer_record_parser_top] OK");
        else
            $display("[dns_answer_record_parser_top] ERROR");
        $finish;
    end

endmodule
